// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold prop on every edge
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// pre implies post in the same cycle
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// pre implies post in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/wrrs_pkg.sv =====
// ---------------------------------------------------------------------------
// wrrs_pkg
// Types, codes and the control store of the weighted round-robin selector.
// ---------------------------------------------------------------------------
`default_nettype none

package wrrs_pkg;

   localparam int SLOT_BITS     = 3;
   localparam int WVAL_BITS     = 16;
   localparam int REQ_DATA_BITS = 24;
   localparam int INDEX_BITS    = 9;
   localparam int STATUS_BITS   = 2;
   localparam int RSP_DATA_BITS = 16;
   localparam int ACTIVE_BITS   = 4;
   localparam int BASE_BITS     = 8;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 8;
   localparam int UPC_BITS      = 4;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 4'd1;

   localparam logic [CSR_IDX_BITS-1:0] REG_ACTIVE_SLOTS = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE_INDEX   = 1'b1;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_SELECT   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_LOAD_ACK = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ERROR    = 2'd2;

   typedef logic [UPC_BITS-1:0] upc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TAKE,
      OP_LOAD,
      OP_REF_INIT,
      OP_REF_READ,
      OP_REF_MAX,
      OP_GCD_STEP,
      OP_GCD_FIN,
      OP_K_INC,
      OP_REF_END,
      OP_ERR,
      OP_ADVANCE,
      OP_TEST,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_SELECT,
      C_FRESH,
      C_SKIP_GCD,
      C_GCD_BUSY,
      C_K_MORE,
      C_MX_LIVE,
      C_MISS,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ctl_word_type;

   typedef struct packed {
      logic no_req;
      logic select;
      logic fresh;
      logic skip_gcd;
      logic gcd_busy;
      logic k_more;
      logic mx_live;
      logic miss;
      logic out_busy;
   } flag_type;

   localparam upc_type UP_WAIT     = 4'd0;
   localparam upc_type UP_DISPATCH = 4'd1;
   localparam upc_type UP_LOAD     = 4'd2;
   localparam upc_type UP_SEL      = 4'd3;
   localparam upc_type UP_REF_INIT = 4'd4;
   localparam upc_type UP_REF_READ = 4'd5;
   localparam upc_type UP_REF_MAX  = 4'd6;
   localparam upc_type UP_GCD      = 4'd7;
   localparam upc_type UP_GCD_FIN  = 4'd8;
   localparam upc_type UP_REF_NEXT = 4'd9;
   localparam upc_type UP_REF_END  = 4'd10;
   localparam upc_type UP_CHECK    = 4'd11;
   localparam upc_type UP_ERR      = 4'd12;
   localparam upc_type UP_ADV      = 4'd13;
   localparam upc_type UP_TEST     = 4'd14;
   localparam upc_type UP_EMIT     = 4'd15;

   // control store; the emit step falls through by wrapping to the wait step
   function automatic ctl_word_type ucode_word(input upc_type upc);
      ctl_word_type w;
      case (upc)
         UP_WAIT:     w = '{OP_TAKE,     C_NO_REQ,   UP_WAIT};
         UP_DISPATCH: w = '{OP_NOP,      C_SELECT,   UP_SEL};
         UP_LOAD:     w = '{OP_LOAD,     C_ALWAYS,   UP_EMIT};
         UP_SEL:      w = '{OP_NOP,      C_FRESH,    UP_CHECK};
         UP_REF_INIT: w = '{OP_REF_INIT, C_NEVER,    UP_WAIT};
         UP_REF_READ: w = '{OP_REF_READ, C_NEVER,    UP_WAIT};
         UP_REF_MAX:  w = '{OP_REF_MAX,  C_SKIP_GCD, UP_REF_NEXT};
         UP_GCD:      w = '{OP_GCD_STEP, C_GCD_BUSY, UP_GCD};
         UP_GCD_FIN:  w = '{OP_GCD_FIN,  C_NEVER,    UP_WAIT};
         UP_REF_NEXT: w = '{OP_K_INC,    C_K_MORE,   UP_REF_READ};
         UP_REF_END:  w = '{OP_REF_END,  C_NEVER,    UP_WAIT};
         UP_CHECK:    w = '{OP_NOP,      C_MX_LIVE,  UP_ADV};
         UP_ERR:      w = '{OP_ERR,      C_ALWAYS,   UP_EMIT};
         UP_ADV:      w = '{OP_ADVANCE,  C_NEVER,    UP_WAIT};
         UP_TEST:     w = '{OP_TEST,     C_MISS,     UP_ADV};
         UP_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, UP_EMIT};
         default:     w = '{OP_NOP,      C_ALWAYS,   UP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/weighted_round_robin_selector.sv =====
// ---------------------------------------------------------------------------
// weighted_round_robin_selector
// Interleaved weighted round-robin selector run by a microcoded sequencer.
// ---------------------------------------------------------------------------
//  channel  dir  ports                         payload
//  req_     in   tvalid tready tdata tuser     slot, weight_value / command
//  rsp_     out  tvalid tready tdata tuser     selected_index / status
//  csr_     in   we index wdata                active_slots, base_index
//
//  A load goes through the steps take, decode, write and emit. A select with
//  up-to-date largest weight and gcd goes through take, decode, freshness test,
//  check, then advance and test until a hit (at most 2n+1 advances), and emit;
//  an all-zero table goes from check to an error step and emit. After a load or
//  an active_slots write the next select first rescans the n active slots, plus
//  for each further non-zero weight the binary gcd steps (at most about
//  2*WEIGHT_BITS) and a finishing step. Reset is synchronous; no clearing pass.
//  A stalled result holds in the output register while the next transaction is
//  taken; the one after waits in the emit step until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module weighted_round_robin_selector #(
   parameter int MAX_SLOTS   = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // [2:0] slot, [18:3] weight_value, [23:19] zero
   input  wire  [wrrs_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // [0] command
   input  wire                                    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // [8:0] selected_index, [15:9] zero
   output logic [wrrs_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // [1:0] status
   output logic [wrrs_pkg::STATUS_BITS-1:0]       rsp_tuser,
   input  wire                                    csr_we,
   input  wire  [wrrs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire  [wrrs_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import wrrs_pkg::*;

   ctl_word_type ctl;
   flag_type     flags;

   wrrs_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   wrrs_dpath #(
      .MAX_SLOTS   (MAX_SLOTS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   `ASSERT_NEXT(a_take_once, req_tvalid && req_tready, !req_tready, "back-to-back take")
   `ASSERT_IMPLIES(a_rsp_from_emit, $rose(rsp_tvalid), $past(ctl.op == OP_EMIT), "stray result")
   `ASSERT_IMPLIES(a_zero_index, rsp_tvalid && (rsp_tuser != ST_SELECT), rsp_tdata == '0, "bad index")

endmodule

`default_nettype wire

// ===== hdl/wrrs_useq.sv =====
// ---------------------------------------------------------------------------
// wrrs_useq
// Step counter and control store with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module wrrs_useq (
   input  wire                      clock,
   input  wire                      reset,
   input  wire wrrs_pkg::flag_type  flags,
   output wrrs_pkg::ctl_word_type   ctl
);
   import wrrs_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    taken;

   assign ctl = ucode_word(upc_ff);

   always_comb begin
      case (ctl.cond)
         C_NEVER:    taken = 1'b0;
         C_ALWAYS:   taken = 1'b1;
         C_NO_REQ:   taken = flags.no_req;
         C_SELECT:   taken = flags.select;
         C_FRESH:    taken = flags.fresh;
         C_SKIP_GCD: taken = flags.skip_gcd;
         C_GCD_BUSY: taken = flags.gcd_busy;
         C_K_MORE:   taken = flags.k_more;
         C_MX_LIVE:  taken = flags.mx_live;
         C_MISS:     taken = flags.miss;
         C_OUT_BUSY: taken = flags.out_busy;
         default:    taken = 1'b0;
      endcase
      upc_in = taken ? ctl.target : upc_ff + upc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UP_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/wrrs_dpath.sv =====
// ---------------------------------------------------------------------------
// wrrs_dpath
// Weight store, derived-value refresh with binary gcd, rotation and result.
// ---------------------------------------------------------------------------
`default_nettype none

module wrrs_dpath #(
   parameter int MAX_SLOTS   = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire wrrs_pkg::ctl_word_type            ctl,
   output wrrs_pkg::flag_type                     flags,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [wrrs_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  wire                                    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [wrrs_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic [wrrs_pkg::STATUS_BITS-1:0]       rsp_tuser,
   input  wire                                    csr_we,
   input  wire  [wrrs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire  [wrrs_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import wrrs_pkg::*;

   localparam int WB = WEIGHT_BITS;
   localparam int AW = $clog2(MAX_SLOTS);
   localparam int NW = $clog2(MAX_SLOTS + 1);
   localparam int TW = WEIGHT_BITS + 2;
   localparam int SW = $clog2(WEIGHT_BITS + 1);

   // latched transaction
   logic                   cmd_ff, cmd_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [WVAL_BITS-1:0]   wval_ff, wval_in;

   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;

   logic [WB-1:0]          weight_mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]   valid_ff, valid_in;
   logic [WB-1:0]          rd_ff;
   logic                   rd_valid_ff;

   logic [AW-1:0]          k_ff, k_in;
   logic [AW-1:0]          cursor_ff, cursor_in;
   logic signed [TW-1:0]   thr_ff, thr_in;
   logic [WB-1:0]          largest_ff, largest_in;
   logic [WB-1:0]          step_ff, step_in;
   logic                   stale_ff, stale_in;
   logic [WB-1:0]          mx_ff, mx_in;
   logic [WB-1:0]          g_ff, g_in;
   logic [WB-1:0]          a_ff, a_in;
   logic [WB-1:0]          b_ff, b_in;
   logic [SW-1:0]          sh_ff, sh_in;
   logic [INDEX_BITS-1:0]  res_index_ff, res_index_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   take;
   logic                   out_busy;
   logic [NW-1:0]          n_cur;
   logic [NW-1:0]          n_cfg;
   logic [NW-1:0]          cur_inc;
   logic [AW-1:0]          cur_next;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic                   mem_we;
   logic [WB-1:0]          rd_word;
   logic signed [TW-1:0]   thr_dec;
   logic                   hit;

   function automatic logic [NW-1:0] slots_in_use(input logic [ACTIVE_BITS-1:0] a);
      logic [NW-1:0] n;
      if (a == '0) begin
         n = NW'(1);
      end else if (int'(a) > MAX_SLOTS) begin
         n = NW'(MAX_SLOTS);
      end else begin
         n = NW'(a);
      end
      return n;
   endfunction

   assign take       = (ctl.op == OP_TAKE) && req_tvalid;
   assign req_tready = (ctl.op == OP_TAKE);
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign n_cur    = slots_in_use(active_ff);
   assign n_cfg    = slots_in_use(csr_wdata[ACTIVE_BITS-1:0]);
   assign cur_inc  = NW'(cursor_ff) + NW'(1);
   assign cur_next = (cur_inc >= n_cur) ? '0 : AW'(cur_inc);
   assign rd_addr  = (ctl.op == OP_ADVANCE) ? cur_next : k_ff;
   assign wr_addr  = AW'(slot_ff);
   assign mem_we   = (ctl.op == OP_LOAD) && (int'(slot_ff) < MAX_SLOTS);
   assign rd_word  = rd_valid_ff ? rd_ff : '0;
   assign thr_dec  = thr_ff - $signed({2'b00, step_ff});
   assign hit      = $signed({2'b00, rd_word}) >= thr_ff;

   assign flags.no_req   = !req_tvalid;
   assign flags.select   = (cmd_ff == CMD_SELECT);
   assign flags.fresh    = !stale_ff;
   assign flags.skip_gcd = (rd_word == '0) || (g_ff == '0);
   assign flags.gcd_busy = (a_ff != b_ff);
   assign flags.k_more   = (NW'(k_ff) + NW'(1)) < n_cur;
   assign flags.mx_live  = (largest_ff != '0);
   assign flags.miss     = !hit;
   assign flags.out_busy = out_busy;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_index_ff);
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      wval_in       = wval_ff;
      active_in     = active_ff;
      base_in       = base_ff;
      valid_in      = valid_ff;
      k_in          = k_ff;
      cursor_in     = cursor_ff;
      thr_in        = thr_ff;
      largest_in    = largest_ff;
      step_in       = step_ff;
      stale_in      = stale_ff;
      mx_in         = mx_ff;
      g_in          = g_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      sh_in         = sh_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;

      case (ctl.op)
         OP_TAKE: begin
            if (take) begin
               cmd_in  = req_tuser;
               slot_in = req_tdata[SLOT_BITS-1:0];
               wval_in = req_tdata[SLOT_BITS +: WVAL_BITS];
            end
         end
         OP_LOAD: begin
            if (mem_we) begin
               valid_in[wr_addr] = 1'b1;
            end
            cursor_in     = AW'(n_cur - NW'(1));
            thr_in        = '0;
            stale_in      = 1'b1;
            res_index_in  = '0;
            res_status_in = ST_LOAD_ACK;
         end
         OP_REF_INIT: begin
            k_in  = '0;
            mx_in = '0;
            g_in  = '0;
         end
         OP_REF_MAX: begin
            if (rd_word > mx_ff) begin
               mx_in = rd_word;
            end
            if (rd_word != '0 && g_ff == '0) begin
               g_in = rd_word;
            end
            a_in  = g_ff;
            b_in  = rd_word;
            sh_in = '0;
         end
         OP_GCD_STEP: begin
            if (a_ff != b_ff) begin
               if (!a_ff[0] && !b_ff[0]) begin
                  a_in  = a_ff >> 1;
                  b_in  = b_ff >> 1;
                  sh_in = sh_ff + SW'(1);
               end else if (!a_ff[0]) begin
                  a_in = a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_in = b_ff >> 1;
               end else if (a_ff > b_ff) begin
                  a_in = (a_ff - b_ff) >> 1;
               end else begin
                  b_in = (b_ff - a_ff) >> 1;
               end
            end
         end
         OP_GCD_FIN: begin
            g_in = a_ff << sh_ff;
         end
         OP_K_INC: begin
            k_in = k_ff + AW'(1);
         end
         OP_REF_END: begin
            largest_in = mx_ff;
            step_in    = g_ff;
            stale_in   = 1'b0;
         end
         OP_ERR: begin
            res_index_in  = '0;
            res_status_in = ST_ERROR;
         end
         OP_ADVANCE: begin
            cursor_in = cur_next;
            if (cur_next == '0) begin
               if (thr_dec[TW-1] || thr_dec == '0) begin
                  thr_in = $signed({2'b00, largest_ff});
               end else begin
                  thr_in = thr_dec;
               end
            end
         end
         OP_TEST: begin
            if (hit) begin
               res_index_in  = INDEX_BITS'(base_ff) + INDEX_BITS'(cursor_ff);
               res_status_in = ST_SELECT;
            end
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            REG_ACTIVE_SLOTS: begin
               active_in = csr_wdata[ACTIVE_BITS-1:0];
               cursor_in = AW'(n_cfg - NW'(1));
               thr_in    = '0;
               stale_in  = 1'b1;
            end
            REG_BASE_INDEX: begin
               base_in = csr_wdata[BASE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[wr_addr] <= WB'(wval_ff);
      end
      rd_ff <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         base_ff      <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         cursor_ff    <= AW'(slots_in_use(ACTIVE_RESET) - NW'(1));
         thr_ff       <= '0;
         largest_ff   <= '0;
         step_ff      <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
         cursor_ff    <= cursor_in;
         thr_ff       <= thr_in;
         largest_ff   <= largest_in;
         step_ff      <= step_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      wval_ff       <= wval_in;
      k_ff          <= k_in;
      mx_ff         <= mx_in;
      g_ff          <= g_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      sh_ff         <= sh_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire
